[sv/kot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kot_pkg
// shared constants, status codes and controller/datapath command types
// ----------------------------------------------------------------------------
package kot_pkg;
	localparam int TABLE_SLOTS_DEF = 4096;
	localparam int MAX_GENOMES_DEF = 1024;
	localparam int PROBE_LIMIT_DEF = 16;

	localparam logic [5:0] KMER_LEN_RST = 6'd25;
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam logic [12:0] FILL_MAX = 13'h1FFF;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_SAME = 3'd2;
	localparam logic [2:0] ST_SHARED = 3'd3;
	localparam logic [2:0] ST_REV_MISS = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [10:0] OWNER_SHARED = 11'h7FF;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, update window
		logic clr_go;    // clear pass step
		logic hash_a;    // hash stage a (partial products)
		logic hash_b;    // hash stage b (sum, home slot)
		logic rd_issue;  // issue memory read at probe slot
		logic evaluate;  // compare read data, maybe write, advance
		logic out_load;  // load output register
	} kot_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic do_table;  // window completed and genome in range
		logic probe_end; // evaluate finished the probe
	} kot_sts_t;
endpackage
`default_nettype wire

[sv/kot_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kot_datapath
// window register, hash multiplier, table memories, probe logic, output reg
// ----------------------------------------------------------------------------
module kot_datapath import kot_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int MAX_GENOMES = MAX_GENOMES_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire kot_cmd_t    cmd,
	output      kot_sts_t    sts,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        op,
	input  wire logic [7:0]  base_char,
	input  wire logic [9:0]  genome_id,
	input  wire logic        reverse_pass,
	input  wire logic        seq_start,
	input  wire logic [11:0] entry_index,
	output      logic        kmer_done,
	output      logic [63:0] kmer_key,
	output      logic [2:0]  table_status,
	output      logic        entry_used,
	output      logic signed [10:0] entry_owner
);
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int LIM = (PROBE_LIMIT > TABLE_SLOTS) ? TABLE_SLOTS : PROBE_LIMIT;
	localparam int PW = $clog2(LIM + 1);

	logic [5:0] kmer_len_q;
	logic [63:0] window_q;
	logic [5:0] run_q;
	logic [12:0] fill_q;
	logic [63:0] key_q;
	logic [10:0] gid_q;
	logic rev_q, isread_q, dotab_q, done_q, idx_ok_q;
	logic [2:0] stat_q;
	logic [AW-1:0] slot_q;
	logic [PW-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	logic clr_done_q;

	logic [63:0] mem_key [TABLE_SLOTS];
	logic [10:0] mem_own [TABLE_SLOTS];
	logic        mem_used [TABLE_SLOTS];
	logic [63:0] rd_key_q;
	logic [10:0] rd_own_q;
	logic        rd_used_q;

	// hash partial products
	logic [63:0] pp_ll_q, pp_lh_q, pp_hl_q;

	logic [5:0] k_eff;
	logic [63:0] mask, win_nxt;
	logic [1:0] code;
	logic code_ok;
	logic [6:0] run_nxt;
	logic [63:0] h;

	always_comb begin
		k_eff = kmer_len_q;
		if (kmer_len_q < 6'd2) k_eff = 6'd2;
		if (kmer_len_q > 6'd32) k_eff = 6'd32;
		mask = (k_eff == 6'd32) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
		code_ok = 1'b1;
		code = 2'd0;
		case (base_char)
			CHAR_A: code = 2'd0;
			CHAR_T: code = 2'd1;
			CHAR_C: code = 2'd2;
			CHAR_G: code = 2'd3;
			default: code_ok = 1'b0;
		endcase
		win_nxt = (((seq_start ? 64'd0 : window_q) << 2) | {62'd0, code}) & mask;
		run_nxt = {1'b0, seq_start ? 6'd0 : run_q};
		if (run_nxt < {1'b0, k_eff}) run_nxt = run_nxt + 7'd1;
		// bits 63:32 of the 128-bit product, only low 64 of product needed
		h = pp_ll_q + {pp_lh_q[31:0], 32'd0} + {pp_hl_q[31:0], 32'd0};
	end

	logic hit_used, hit_match;
	assign hit_used = rd_used_q;
	assign hit_match = rd_key_q == key_q;

	assign sts.clr_done = clr_done_q;
	assign sts.is_read = isread_q;
	assign sts.do_table = dotab_q;
	assign sts.probe_end = !hit_used || hit_match || (cnt_q == PW'(LIM - 1));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= KMER_LEN_RST;
			window_q <= '0;
			run_q <= '0;
			fill_q <= '0;
			clr_q <= '0;
			clr_done_q <= 1'b0;
			dotab_q <= 1'b0;
			isread_q <= 1'b0;
		end else begin
			if (cfg_we) kmer_len_q <= cfg_data;
			if (cmd.clr_go) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(TABLE_SLOTS - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.load) begin
				isread_q <= op == OP_READ;
				dotab_q <= (op == OP_FEED) && code_ok && (run_nxt[5:0] >= k_eff)
					&& ({22'd0, genome_id} < 32'(MAX_GENOMES));
				if (op == OP_FEED) begin
					if (!code_ok) begin
						window_q <= '0;
						run_q <= '0;
					end else begin
						window_q <= win_nxt;
						run_q <= run_nxt[5:0];
					end
				end
			end
			if (cmd.evaluate && !rev_q && !hit_used && fill_q != FILL_MAX)
				fill_q <= fill_q + 13'd1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gid_q <= {1'b0, genome_id};
			rev_q <= reverse_pass;
			done_q <= (op == OP_FEED) && code_ok && (run_nxt[5:0] >= k_eff);
			key_q <= (op == OP_READ) ? 64'd0 : win_nxt;
			idx_ok_q <= {20'd0, entry_index} < 32'(TABLE_SLOTS);
			slot_q <= AW'(entry_index);
			cnt_q <= '0;
			stat_q <= ST_NONE;
		end
		if (cmd.hash_a) begin
			pp_ll_q <= 64'(key_q[31:0] * HASH_MULT[31:0]);
			pp_lh_q <= 64'(key_q[31:0] * HASH_MULT[63:32]);
			pp_hl_q <= 64'(key_q[63:32] * HASH_MULT[31:0]);
		end
		if (cmd.hash_b) slot_q <= AW'(h[63:32]);
		if (cmd.evaluate) begin
			if (!hit_used) stat_q <= rev_q ? ST_REV_MISS : ST_INSERTED;
			else if (hit_match)
				stat_q <= (rd_own_q == gid_q) ? ST_SAME : ST_SHARED;
			else if (cnt_q == PW'(LIM - 1))
				stat_q <= rev_q ? ST_REV_MISS : ST_FULL;
			slot_q <= slot_q + AW'(1);
			cnt_q <= cnt_q + PW'(1);
		end
		// output register only changes when a result is loaded
		if (cmd.out_load) begin
			kmer_done <= done_q && !isread_q;
			table_status <= stat_q;
			if (isread_q && idx_ok_q && rd_used_q) begin
				kmer_key <= rd_key_q;
				entry_used <= 1'b1;
				entry_owner <= rd_own_q;
			end else begin
				kmer_key <= done_q && !isread_q ? key_q : 64'd0;
				entry_used <= 1'b0;
				entry_owner <= '0;
			end
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (cmd.clr_go) mem_used[clr_q] <= 1'b0;
		if (cmd.evaluate) begin
			if (!hit_used && !rev_q) begin
				mem_used[slot_q] <= 1'b1;
				mem_key[slot_q] <= key_q;
				mem_own[slot_q] <= gid_q;
			end else if (hit_used && hit_match && rd_own_q != gid_q)
				mem_own[slot_q] <= OWNER_SHARED;
		end
		if (cmd.rd_issue) begin
			rd_key_q <= mem_key[slot_q];
			rd_own_q <= mem_own[slot_q];
			rd_used_q <= mem_used[slot_q];
		end
	end
endmodule
`default_nettype wire

[sv/kot_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kot_ctrl
// sequencer: clear pass, request capture, hash, probe loop, output handshake
// ----------------------------------------------------------------------------
module kot_ctrl import kot_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_stall,
	output      logic     out_valid,
	input  wire logic     out_stall,
	input  wire kot_sts_t sts,
	output      kot_cmd_t cmd
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASHA = 3'd2;
	localparam logic [2:0] S_HASHB = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_EVAL  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic out_free, accept;

	// output register free once any held result is taken
	assign out_free = !out_valid || !out_stall;
	assign in_stall = state_q != S_IDLE;
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_go = !sts.clr_done;
				if (sts.clr_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				cmd.load = accept;
				if (accept) state_nxt = S_HASHA;
			end
			S_HASHA: begin
				cmd.hash_a = 1'b1;
				if (sts.is_read) begin
					cmd.rd_issue = 1'b1;
					state_nxt = S_OUT;
				end else if (sts.do_table) state_nxt = S_HASHB;
				else state_nxt = S_OUT;
			end
			S_HASHB: begin
				cmd.hash_b = 1'b1;
				state_nxt = S_READ;
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				cmd.evaluate = 1'b1;
				state_nxt = sts.probe_end ? S_OUT : S_READ;
			end
			S_OUT: begin
				cmd.out_load = out_free;
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

[sv/kmer_owner_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_owner_table
// rolling 2-bit k-mer window with a linear-probe owner hash table
// ----------------------------------------------------------------------------
// usage:
//  - input channel in_valid/in_stall carries one request: feed one base
//    (op 0) or read one table slot (op 1); taken when valid and not stall
//  - output channel out_valid/out_stall returns exactly one result per request
//  - user writes kmer_len via cfg_we/cfg_data only while idle (not enforced)
// timing:
//  - read request, or base that does not complete a window: result
//    is registered through the hash-a state and then the output state
//  - window that probes the table: hash-a, hash-b, then a read and an
//    evaluate state per slot visited (1..PROBE_LIMIT, at most TABLE_SLOTS),
//    then the output state; each probe reads and compares one slot
//  - one request at a time; the next is taken in the cycle after the result
//    is registered, so a waiting result only holds up the following result
// reset:
//  - after arst_n rises the slot valid bits of all TABLE_SLOTS slots
//    (4096 by default) are swept and in_stall stays high until done;
//    config writes still work
// stall:
//  - a stalled result holds in the output register; a new result waits
//    in its finishing state until the register frees
// ----------------------------------------------------------------------------
module kmer_owner_table import kot_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int MAX_GENOMES = MAX_GENOMES_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  base_char,
	input  wire logic [9:0]  genome_id,
	input  wire logic        reverse_pass,
	input  wire logic        seq_start,
	input  wire logic [11:0] entry_index,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        kmer_done,
	output      logic [63:0] kmer_key,
	output      logic [2:0]  table_status,
	output      logic        entry_used,
	output      logic signed [10:0] entry_owner
);
	kot_cmd_t cmd;
	kot_sts_t sts;

	// sequencer
	kot_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd
	);

	// window, hash, table and output register
	kot_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS), .MAX_GENOMES(MAX_GENOMES),
		.PROBE_LIMIT(PROBE_LIMIT)
	) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_data,
		.op, .base_char, .genome_id, .reverse_pass, .seq_start, .entry_index,
		.kmer_done, .kmer_key, .table_status, .entry_used, .entry_owner
	);
endmodule
`default_nettype wire

[sv/kot_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kot_checker
// port-level checks on the request and result channels
// ----------------------------------------------------------------------------
module kot_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        kmer_done,
	input wire logic [63:0] kmer_key,
	input wire logic [2:0]  table_status,
	input wire logic        entry_used
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kmer_key))
		else $error("stalled result changed");

	// one request at a time: intake closes right after acceptance
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// table status only when a window completed
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kmer_done |-> table_status == 3'd0)
		else $error("status without window");

	// feed and read results are exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kmer_done |-> !entry_used)
		else $error("feed and read result mixed");
endmodule

bind kmer_owner_table kot_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.kmer_done, .kmer_key, .table_status, .entry_used
);
`default_nettype wire
